FILE: hw/rtl/lsc_pkg.sv
// Shared types, register indexes and constants of the lock sequence controller.
package lsc_pkg;

   // Configuration register indexes
   localparam int unsigned CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_SWITCH_MASK = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CODE_OPEN   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CODE_HALF   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CODE_PULLED = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CODE_PUSHED = 3'd4;

   // Register reset values
   localparam logic [7:0] RST_SWITCH_MASK = 8'd255;
   localparam logic [7:0] RST_CODE_OPEN   = 8'd0;
   localparam logic [7:0] RST_CODE_HALF   = 8'd1;
   localparam logic [7:0] RST_CODE_PULLED = 8'd2;
   localparam logic [7:0] RST_CODE_PUSHED = 8'd3;

   // Task codes toward the planner
   localparam logic [2:0] TASK_NONE     = 3'd0;
   localparam logic [2:0] TASK_PULL     = 3'd1;
   localparam logic [2:0] TASK_PUSH     = 3'd2;
   localparam logic [2:0] TASK_OPEN     = 3'd4;
   localparam logic [2:0] TASK_RECOVERY = 3'd7;

   // Per-state timeouts in ticks
   localparam logic [9:0] TIMEOUT_NONE  = 10'd0;
   localparam logic [9:0] TIMEOUT_SHORT = 10'd100;
   localparam logic [9:0] TIMEOUT_MID   = 10'd300;
   localparam logic [9:0] TIMEOUT_LONG  = 10'd800;

   // Planner speedup commands
   localparam logic [1:0] SPEEDUP_NONE  = 2'd0;
   localparam logic [1:0] SPEEDUP_PULL  = 2'd1;
   localparam logic [1:0] SPEEDUP_DELAY = 2'd2;

   // Lock position codes as seen on the result
   localparam logic [1:0] POS_OPEN = 2'd0;

   typedef struct packed {
      logic [7:0] switch_byte;
      logic       key_pressed;
   } req_type;

   typedef struct packed {
      logic [1:0] lock_state;
      logic [2:0] task_code;
      logic       plan_write;
      logic       pole_enable;
      logic       fault;
      logic       bridge_off;
      logic       signs_clear;
      logic       hall_reload;
      logic [1:0] planner_speedup;
      logic       door_opened;
   } rsp_type;

   typedef struct packed {
      logic [7:0] switch_mask;
      logic [7:0] code_open;
      logic [7:0] code_half;
      logic [7:0] code_pulled;
      logic [7:0] code_pushed;
   } csr_type;

endpackage

FILE: hw/rtl/lock_sequence_controller_top.sv
// Top level of the lock sequence controller: input register, sequencer, result register.
// A tick accepted on req is held in the input register, then moves into the result register and shows on rsp.
// Throughput: one transaction per cycle while rsp_stall is low; the input register and the result register
// both advance in the same cycle through the single-pass state update.
// Reset (synchronous, active high): sequence back to open with a 100-tick timeout,
// no task, marks clear, registers to their defaults, both stages empty.
module lock_sequence_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lsc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lsc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lsc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [7:0]                         csr_wdata
);
   import lsc_pkg::*;

   csr_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance, accept;

   lsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // move the held tick into the result register when that register is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_data_ff <= req_data;
         end
      end
   end

   lsc_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted tick not held in input register");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced tick did not reach the result register");

   a_fault_no_pole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fault && rsp_data.pole_enable))
      else $error("pole enabled while fault mark set");

   a_recovery_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.task_code == TASK_RECOVERY) |-> rsp_data.lock_state == POS_OPEN)
      else $error("recovery task outside open state");

endmodule

FILE: hw/rtl/lsc_csr.sv
// Configuration register bank of the lock sequence controller.
module lsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [7:0]                          csr_wdata,
   output lsc_pkg::csr_type                    cfg
);
   import lsc_pkg::*;

   csr_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.switch_mask <= RST_SWITCH_MASK;
         cfg_ff.code_open   <= RST_CODE_OPEN;
         cfg_ff.code_half   <= RST_CODE_HALF;
         cfg_ff.code_pulled <= RST_CODE_PULLED;
         cfg_ff.code_pushed <= RST_CODE_PUSHED;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SWITCH_MASK: cfg_ff.switch_mask <= csr_wdata;
            CSR_CODE_OPEN:   cfg_ff.code_open   <= csr_wdata;
            CSR_CODE_HALF:   cfg_ff.code_half   <= csr_wdata;
            CSR_CODE_PULLED: cfg_ff.code_pulled <= csr_wdata;
            CSR_CODE_PUSHED: cfg_ff.code_pushed <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

FILE: hw/rtl/lsc_seq.sv
// Lock sequence state machine with its result register.
module lsc_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  lsc_pkg::req_type  req,
   input  lsc_pkg::csr_type  cfg,
   output lsc_pkg::rsp_type  rsp
);
   import lsc_pkg::*;

   typedef enum logic [1:0] {
      ST_OPEN   = 2'd0,
      ST_HALF   = 2'd1,
      ST_PULLED = 2'd2,
      ST_PUSHED = 2'd3
   } state_type;

   state_type  state_ff,   state_in;
   logic [9:0] elapsed_ff, elapsed_in;
   logic [9:0] timeout_ff, timeout_in;
   logic [2:0] task_ff,    task_in;
   logic       pole_ff,    pole_in;
   logic       error_ff,   error_in;
   rsp_type    rsp_ff,     rsp_in;

   logic [7:0] masked;
   logic       running;
   logic       hit_open, hit_half, hit_pulled, hit_pushed;
   logic       p_plan, p_bridge, p_signs, p_hall, p_door;
   logic [1:0] p_speed;

   assign masked     = req.switch_byte & cfg.switch_mask;
   assign running    = elapsed_ff < timeout_ff;
   assign hit_open   = masked == cfg.code_open;
   assign hit_half   = masked == cfg.code_half;
   assign hit_pulled = masked == cfg.code_pulled;
   assign hit_pushed = masked == cfg.code_pushed;

   always_comb begin
      state_in   = state_ff;
      elapsed_in = elapsed_ff;
      timeout_in = timeout_ff;
      task_in    = task_ff;
      pole_in    = pole_ff;
      error_in   = error_ff;
      p_plan     = 1'b0;
      p_bridge   = 1'b0;
      p_signs    = 1'b0;
      p_hall     = 1'b0;
      p_door     = 1'b0;
      p_speed    = SPEEDUP_NONE;

      unique case (state_ff)
         ST_OPEN: begin
            if (task_ff == TASK_RECOVERY) begin
               // recovery pending: ignore switches, count out then drop the task
               if (running) elapsed_in = elapsed_ff + 10'd1;
               else         task_in    = TASK_NONE;
            end else if (hit_open && !error_ff) begin
               elapsed_in = '0;
               timeout_in = TIMEOUT_MID;
               task_in    = TASK_NONE;
               pole_in    = 1'b1;
               error_in   = 1'b0;
            end else if (hit_half && !error_ff) begin
               p_hall     = 1'b1;
               p_bridge   = 1'b1;
               p_signs    = 1'b1;
               p_plan     = 1'b1;
               state_in   = ST_HALF;
               elapsed_in = '0;
               timeout_in = TIMEOUT_MID;
               task_in    = TASK_PULL;
               pole_in    = 1'b0;
               error_in   = 1'b0;
            end else if (hit_pushed && !error_ff) begin
               p_hall     = 1'b1;
               p_bridge   = 1'b1;
               p_signs    = 1'b1;
               state_in   = ST_PUSHED;
               elapsed_in = '0;
               timeout_in = TIMEOUT_MID;
               task_in    = TASK_NONE;
               pole_in    = 1'b0;
               error_in   = 1'b0;
            end else if (running) begin
               elapsed_in = elapsed_ff + 10'd1;
            end else begin
               // error recovery: shut bridges, then wait on the key
               elapsed_in = '0;
               pole_in    = 1'b0;
               p_bridge   = 1'b1;
               p_signs    = 1'b1;
               if (req.key_pressed) begin
                  timeout_in = TIMEOUT_LONG;
                  if (error_ff) begin
                     task_in  = TASK_RECOVERY;
                     p_plan   = 1'b1;
                     error_in = 1'b0;
                  end
               end else begin
                  timeout_in = TIMEOUT_SHORT;
                  error_in   = 1'b1;
               end
            end
         end

         ST_HALF: begin
            if (running) begin
               elapsed_in = elapsed_ff + 10'd1;
               if (hit_pulled) begin
                  p_speed    = SPEEDUP_PULL;
                  p_plan     = 1'b1;
                  state_in   = ST_PULLED;
                  elapsed_in = '0;
                  timeout_in = TIMEOUT_MID;
                  task_in    = TASK_PUSH;
                  pole_in    = 1'b0;
                  error_in   = 1'b0;
               end
            end else begin
               state_in   = ST_OPEN;
               elapsed_in = '0;
               timeout_in = TIMEOUT_SHORT;
               task_in    = TASK_NONE;
               pole_in    = 1'b0;
               error_in   = 1'b1;
            end
         end

         ST_PULLED: begin
            if (running) begin
               elapsed_in = elapsed_ff + 10'd1;
               if (hit_pushed) begin
                  p_signs    = 1'b1;
                  p_speed    = SPEEDUP_DELAY;
                  state_in   = ST_PUSHED;
                  elapsed_in = '0;
                  timeout_in = TIMEOUT_SHORT;
                  task_in    = TASK_NONE;
                  pole_in    = 1'b0;
                  error_in   = 1'b0;
               end
            end else begin
               p_signs    = 1'b1;
               state_in   = ST_OPEN;
               elapsed_in = '0;
               timeout_in = TIMEOUT_SHORT;
               task_in    = TASK_NONE;
               pole_in    = 1'b0;
               error_in   = 1'b1;
            end
         end

         ST_PUSHED: begin
            if (task_ff == TASK_OPEN) begin
               if (running) begin
                  elapsed_in = elapsed_ff + 10'd1;
                  if (hit_open) begin
                     p_door     = 1'b1;
                     state_in   = ST_OPEN;
                     elapsed_in = '0;
                     timeout_in = TIMEOUT_NONE;
                     task_in    = TASK_NONE;
                     pole_in    = 1'b0;
                     error_in   = 1'b0;
                  end
               end else begin
                  p_bridge   = 1'b1;
                  state_in   = ST_OPEN;
                  elapsed_in = '0;
                  timeout_in = TIMEOUT_SHORT;
                  task_in    = TASK_NONE;
                  pole_in    = 1'b0;
                  error_in   = 1'b1;
               end
            end else if (hit_pushed) begin
               // hold pushed and restart the wait; the key requests opening
               if (req.key_pressed) begin
                  p_hall   = 1'b1;
                  p_plan   = 1'b1;
                  p_bridge = 1'b1;
                  p_signs  = 1'b1;
                  task_in  = TASK_OPEN;
                  pole_in  = 1'b0;
                  error_in = 1'b0;
               end
               elapsed_in = '0;
               timeout_in = TIMEOUT_SHORT;
            end else if (running) begin
               elapsed_in = elapsed_ff + 10'd1;
            end else begin
               state_in   = ST_OPEN;
               elapsed_in = '0;
               timeout_in = TIMEOUT_SHORT;
               task_in    = TASK_NONE;
               pole_in    = 1'b0;
               error_in   = 1'b1;
            end
         end

         default: ;
      endcase

      rsp_in.lock_state      = state_in;
      rsp_in.task_code       = task_in;
      rsp_in.plan_write      = p_plan;
      rsp_in.pole_enable     = pole_in;
      rsp_in.fault           = error_in;
      rsp_in.bridge_off      = p_bridge;
      rsp_in.signs_clear     = p_signs;
      rsp_in.hall_reload     = p_hall;
      rsp_in.planner_speedup = p_speed;
      rsp_in.door_opened     = p_door;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_OPEN;
         elapsed_ff <= '0;
         timeout_ff <= TIMEOUT_SHORT;
         task_ff    <= TASK_NONE;
         pole_ff    <= 1'b0;
         error_ff   <= 1'b0;
      end else if (advance) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         timeout_ff <= timeout_in;
         task_ff    <= task_in;
         pole_ff    <= pole_in;
         error_ff   <= error_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: verif/tb_lock_sequence_controller_top.sv
// Self-checking testbench for the lock sequence controller: directed table, then guided random.
`timescale 1ns / 1ps

module tb_lock_sequence_controller_top;
   import lsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 4;

   typedef enum logic [1:0] {
      LOCK_OPEN   = 2'd0,
      LOCK_HALF   = 2'd1,
      LOCK_PULLED = 2'd2,
      LOCK_PUSHED = 2'd3
   } lock_pos_type;

   // One directed row; want is used only when typed is set
   typedef struct packed {
      req_type tick;
      logic    typed;
      rsp_type want;
   } lock_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_SWITCH_MASK;
   logic [7:0] csr_wdata = '0;

   // Predicted lock sequence state and register copy
   lock_pos_type lk_pos;
   logic [9:0] lk_elapsed, lk_timeout;
   logic [2:0] lk_task;
   logic lk_pole, lk_err;
   logic [7:0] cfg_mask, cfg_open, cfg_half, cfg_pulled, cfg_pushed;

   rsp_type due_rsp[$];
   lock_row_type steer_rows[$];
   int bad_rsp = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_asks = 0;
   int holds_done = 0;
   int hold_left = 0;
   bit stuck = 1'b0;
   logic [5:0] stuck_at;
   logic [9:0] stuck_mark;

   lock_sequence_controller_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic void enter_state(lock_pos_type pos, logic [9:0] tmo, logic [2:0] job,
                                       logic pole, logic err);
      lk_pos = pos;
      lk_elapsed = '0;
      lk_timeout = tmo;
      lk_task = job;
      lk_pole = pole;
      lk_err = err;
   endfunction

   function automatic rsp_type lock_step(req_type t);
      rsp_type r;
      logic [7:0] m;
      m = t.switch_byte & cfg_mask;
      r = '0;
      case (lk_pos)
         LOCK_OPEN: begin
            if (lk_task == TASK_RECOVERY) begin
               // recovery pending: switches ignored until the count runs out
               if (lk_elapsed < lk_timeout) lk_elapsed++;
               else lk_task = TASK_NONE;
            end else if (m == cfg_open && !lk_err) begin
               enter_state(LOCK_OPEN, TIMEOUT_MID, TASK_NONE, 1'b1, 1'b0);
            end else if (m == cfg_half && !lk_err) begin
               r.hall_reload = 1'b1;
               r.bridge_off = 1'b1;
               r.signs_clear = 1'b1;
               r.plan_write = 1'b1;
               enter_state(LOCK_HALF, TIMEOUT_MID, TASK_PULL, 1'b0, 1'b0);
            end else if (m == cfg_pushed && !lk_err) begin
               r.hall_reload = 1'b1;
               r.bridge_off = 1'b1;
               r.signs_clear = 1'b1;
               enter_state(LOCK_PUSHED, TIMEOUT_MID, TASK_NONE, 1'b0, 1'b0);
            end else if (lk_elapsed < lk_timeout) begin
               lk_elapsed++;
            end else begin
               lk_pos = LOCK_OPEN;
               lk_elapsed = '0;
               lk_pole = 1'b0;
               r.bridge_off = 1'b1;
               r.signs_clear = 1'b1;
               if (t.key_pressed) begin
                  lk_timeout = TIMEOUT_LONG;
                  if (lk_err) begin
                     lk_task = TASK_RECOVERY;
                     r.plan_write = 1'b1;
                     lk_err = 1'b0;
                  end
               end else begin
                  lk_timeout = TIMEOUT_SHORT;
                  lk_err = 1'b1;
               end
            end
         end
         LOCK_HALF: begin
            if (lk_elapsed < lk_timeout) begin
               lk_elapsed++;
               if (m == cfg_pulled) begin
                  r.planner_speedup = SPEEDUP_PULL;
                  r.plan_write = 1'b1;
                  enter_state(LOCK_PULLED, TIMEOUT_MID, TASK_PUSH, 1'b0, 1'b0);
               end
            end else begin
               enter_state(LOCK_OPEN, TIMEOUT_SHORT, TASK_NONE, 1'b0, 1'b1);
            end
         end
         LOCK_PULLED: begin
            r.signs_clear = 1'b1;
            if (lk_elapsed < lk_timeout) begin
               lk_elapsed++;
               if (m == cfg_pushed) begin
                  r.planner_speedup = SPEEDUP_DELAY;
                  enter_state(LOCK_PUSHED, TIMEOUT_SHORT, TASK_NONE, 1'b0, 1'b0);
               end else begin
                  r.signs_clear = 1'b0;
               end
            end else begin
               enter_state(LOCK_OPEN, TIMEOUT_SHORT, TASK_NONE, 1'b0, 1'b1);
            end
         end
         LOCK_PUSHED: begin
            if (lk_task == TASK_OPEN) begin
               if (lk_elapsed < lk_timeout) begin
                  lk_elapsed++;
                  if (m == cfg_open) begin
                     r.door_opened = 1'b1;
                     enter_state(LOCK_OPEN, TIMEOUT_NONE, TASK_NONE, 1'b0, 1'b0);
                  end
               end else begin
                  r.bridge_off = 1'b1;
                  enter_state(LOCK_OPEN, TIMEOUT_SHORT, TASK_NONE, 1'b0, 1'b1);
               end
            end else if (m == cfg_pushed) begin
               if (t.key_pressed) begin
                  r.hall_reload = 1'b1;
                  r.plan_write = 1'b1;
                  r.bridge_off = 1'b1;
                  r.signs_clear = 1'b1;
                  enter_state(LOCK_PUSHED, TIMEOUT_SHORT, TASK_OPEN, 1'b0, 1'b0);
               end
               lk_elapsed = '0;
               lk_timeout = TIMEOUT_SHORT;
            end else if (lk_elapsed < lk_timeout) begin
               lk_elapsed++;
            end else begin
               enter_state(LOCK_OPEN, TIMEOUT_SHORT, TASK_NONE, 1'b0, 1'b1);
            end
         end
      endcase
      r.lock_state = lk_pos;
      r.task_code = lk_task;
      r.pole_enable = lk_pole;
      r.fault = lk_err;
      return r;
   endfunction

   // Random tick, steered toward the code the current state waits for
   function automatic req_type pick_tick();
      req_type t;
      logic [7:0] aim;
      bit guided;
      t.switch_byte = 8'($urandom_range(255));
      t.key_pressed = 1'($urandom_range(1));
      aim = '0;
      guided = 1'b0;
      // drop a stuck run once the state moved or its counter restarted
      if (stuck && ({lk_pos, lk_task, lk_err} != stuck_at || lk_elapsed < stuck_mark))
         stuck = 1'b0;
      stuck_mark = lk_elapsed;
      if (!stuck && $urandom_range(249) == 0) begin
         stuck = 1'b1;
         stuck_at = {lk_pos, lk_task, lk_err};
      end
      if (stuck || $urandom_range(99) < 15) return t;
      case (lk_pos)
         LOCK_OPEN: begin
            if (lk_err) begin
               t.key_pressed = ($urandom_range(3) == 0);
            end else if (lk_task != TASK_RECOVERY) begin
               guided = 1'b1;
               case ($urandom_range(99)) inside
                  [0:59]:  aim = cfg_half;
                  [60:74]: aim = cfg_pushed;
                  default: aim = cfg_open;
               endcase
            end
         end
         LOCK_HALF: begin
            guided = ($urandom_range(99) < 40);
            aim = cfg_pulled;
         end
         LOCK_PULLED: begin
            guided = ($urandom_range(99) < 40);
            aim = cfg_pushed;
         end
         LOCK_PUSHED: begin
            if (lk_task == TASK_OPEN) begin
               guided = ($urandom_range(99) < 40);
               aim = cfg_open;
            end else begin
               guided = ($urandom_range(99) < 60);
               aim = cfg_pushed;
            end
         end
      endcase
      if (guided) t.switch_byte = (aim & cfg_mask) | (t.switch_byte & ~cfg_mask);
      return t;
   endfunction

   function automatic rsp_type rsp_of(logic [1:0] lock, logic [2:0] job, logic plan, logic pole,
                                      logic fault, logic bridge, logic signs, logic hall,
                                      logic [1:0] speed, logic door);
      rsp_type r;
      r = '{lock, job, plan, pole, fault, bridge, signs, hall, speed, door};
      return r;
   endfunction

   function automatic lock_row_type row(logic [7:0] sw, logic key, logic typed, rsp_type want);
      lock_row_type w;
      w.tick.switch_byte = sw;
      w.tick.key_pressed = key;
      w.typed = typed;
      w.want = want;
      return w;
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf({"pos %0d task %0d plan %0b pole %0b fault %0b bridge %0b ",
                        "signs %0b hall %0b speedup %0d door %0b"},
                       r.lock_state, r.task_code, r.plan_write, r.pole_enable, r.fault,
                       r.bridge_off, r.signs_clear, r.hall_reload, r.planner_speedup,
                       r.door_opened);
   endfunction

   task automatic report_bad(input string what, input rsp_type want, input rsp_type got);
      bad_rsp++;
      if (bad_rsp <= 10) begin
         $display("%0t rsp %s", $realtime, what);
         $display("   expected %s", rsp_text(want));
         $display("   actual   %s", rsp_text(got));
      end
   endtask

   task automatic send_tick(input req_type t, input logic typed, input rsp_type want);
      int gap;
      rsp_type model;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model = lock_step(t);
      due_rsp.push_back(typed ? want : model);
   endtask

   task automatic run_random(input int count, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            // hold input until the block has emptied out
            req_valid <= 1'b0;
            while (due_rsp.size() != 0) @(posedge clock);
         end
         send_tick(pick_tick(), 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_codes(input logic [7:0] mask, input logic [7:0] open_c,
                             input logic [7:0] half_c, input logic [7:0] pulled_c,
                             input logic [7:0] pushed_c);
      logic [CsrIndexWidth-1:0] idx [5];
      logic [7:0] vals [5];
      idx = '{CSR_SWITCH_MASK, CSR_CODE_OPEN, CSR_CODE_HALF, CSR_CODE_PULLED, CSR_CODE_PUSHED};
      vals = '{mask, open_c, half_c, pulled_c, pushed_c};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            CSR_SWITCH_MASK: cfg_mask = vals[i];
            CSR_CODE_OPEN:   cfg_open = vals[i];
            CSR_CODE_HALF:   cfg_half = vals[i];
            CSR_CODE_PULLED: cfg_pulled = vals[i];
            CSR_CODE_PUSHED: cfg_pushed = vals[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp.size() == 0) begin
               report_bad("without a pending tick", '0, rsp_data);
            end else begin
               want = due_rsp.pop_front();
               if (rsp_data.lock_state !== want.lock_state
                   || rsp_data.task_code !== want.task_code
                   || rsp_data.plan_write !== want.plan_write
                   || rsp_data.pole_enable !== want.pole_enable
                   || rsp_data.fault !== want.fault
                   || rsp_data.bridge_off !== want.bridge_off
                   || rsp_data.signs_clear !== want.signs_clear
                   || rsp_data.hall_reload !== want.hall_reload
                   || rsp_data.planner_speedup !== want.planner_speedup
                   || rsp_data.door_opened !== want.door_opened)
                  report_bad("mismatch", want, rsp_data);
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (holds_done != hold_asks) begin
            // long hold-off so the block backs up into its input
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_lock_sequence_controller_top: errors");
         $finish;
      end
   end

   initial begin
      cfg_mask = RST_SWITCH_MASK;
      cfg_open = RST_CODE_OPEN;
      cfg_half = RST_CODE_HALF;
      cfg_pulled = RST_CODE_PULLED;
      cfg_pushed = RST_CODE_PUSHED;
      enter_state(LOCK_OPEN, TIMEOUT_SHORT, TASK_NONE, 1'b0, 1'b0);

      // walk open -> half -> pulled -> pushed -> door open, then the zero timeout
      steer_rows.push_back(row(8'h00, 1'b0, 1'b1, rsp_of(LOCK_OPEN, TASK_NONE, 1'b0, 1'b1,
                           1'b0, 1'b0, 1'b0, 1'b0, SPEEDUP_NONE, 1'b0)));
      steer_rows.push_back(row(8'h01, 1'b0, 1'b1, rsp_of(LOCK_HALF, TASK_PULL, 1'b1, 1'b0,
                           1'b0, 1'b1, 1'b1, 1'b1, SPEEDUP_NONE, 1'b0)));
      steer_rows.push_back(row(8'h80, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h02, 1'b0, 1'b1, rsp_of(LOCK_PULLED, TASK_PUSH, 1'b1, 1'b0,
                           1'b0, 1'b0, 1'b0, 1'b0, SPEEDUP_PULL, 1'b0)));
      steer_rows.push_back(row(8'hFE, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h03, 1'b0, 1'b1, rsp_of(LOCK_PUSHED, TASK_NONE, 1'b0, 1'b0,
                           1'b0, 1'b0, 1'b1, 1'b0, SPEEDUP_DELAY, 1'b0)));
      steer_rows.push_back(row(8'h03, 1'b0, 1'b0, '0));
      steer_rows.push_back(row(8'h7F, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h03, 1'b1, 1'b1, rsp_of(LOCK_PUSHED, TASK_OPEN, 1'b1, 1'b0,
                           1'b0, 1'b1, 1'b1, 1'b1, SPEEDUP_NONE, 1'b0)));
      steer_rows.push_back(row(8'h55, 1'b0, 1'b0, '0));
      steer_rows.push_back(row(8'h00, 1'b0, 1'b1, rsp_of(LOCK_OPEN, TASK_NONE, 1'b0, 1'b0,
                           1'b0, 1'b0, 1'b0, 1'b0, SPEEDUP_NONE, 1'b1)));
      steer_rows.push_back(row(8'hFF, 1'b1, 1'b1, rsp_of(LOCK_OPEN, TASK_NONE, 1'b0, 1'b0,
                           1'b0, 1'b1, 1'b1, 1'b0, SPEEDUP_NONE, 1'b0)));
      steer_rows.push_back(row(8'h03, 1'b0, 1'b1, rsp_of(LOCK_PUSHED, TASK_NONE, 1'b0, 1'b0,
                           1'b0, 1'b1, 1'b1, 1'b1, SPEEDUP_NONE, 1'b0)));
      steer_rows.push_back(row(8'h00, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h03, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h00, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h00, 1'b0, 1'b0, '0));
      steer_rows.push_back(row(8'hAA, 1'b0, 1'b0, '0));
      steer_rows.push_back(row(8'h01, 1'b1, 1'b0, '0));
      steer_rows.push_back(row(8'h00, 1'b0, 1'b0, '0));
      steer_rows.push_back(row(8'hFF, 1'b1, 1'b0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 14;
      rsp_idle_pct = 60;
      foreach (steer_rows[i])
         send_tick(steer_rows[i].tick, steer_rows[i].typed, steer_rows[i].want);
      run_random(430, -1);
      drain();

      // overlapping half and pulled codes under a sparse mask
      load_codes(8'hC3, 8'h00, 8'h41, 8'h41, 8'h82);
      req_idle_pct = 60;
      rsp_idle_pct = 14;
      run_random(430, 200);
      drain();

      load_codes(8'hFF, 8'hFF, 8'h80, 8'h7F, 8'h01);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_asks <= hold_asks + 1;
      run_random(400, -1);
      drain();

      // empty mask: every code but open matches every byte
      load_codes(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
      run_random(100, -1);

      while (due_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (bad_rsp == 0 && due_rsp.size() == 0) begin
         $display("tb_lock_sequence_controller_top: clean");
      end else begin
         $display("tb_lock_sequence_controller_top: errors");
      end
      $finish;
   end

endmodule
